// ===== hw/rtl/csb_pkg.sv =====
// ----------------------------------------------------------------------------
// csb_pkg: shared types and codes for the cursor sequence buffer
// Item formats, command and status codes, and the control/status bundles
// between the sequencer and the datapath.
// ----------------------------------------------------------------------------
package csb_pkg;

    localparam int CSB_CAPACITY   = 64;
    localparam int CSB_DATA_WIDTH = 32;

    localparam logic [2:0] KIND_START   = 3'd0;
    localparam logic [2:0] KIND_ADVANCE = 3'd1;
    localparam logic [2:0] KIND_INSERT  = 3'd2;
    localparam logic [2:0] KIND_ATTACH  = 3'd3;
    localparam logic [2:0] KIND_REMOVE  = 3'd4;
    localparam logic [2:0] KIND_READ    = 3'd5;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NO_ITEM = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_RANGE   = 2'd3;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] entry_value;
        logic [5:0]  read_index;
    } csb_cmd_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic        current_valid;
        logic [31:0] current_value;
        logic [31:0] read_value;
        logic [6:0]  item_count;
        logic [6:0]  cursor_position;
    } csb_rsp_item_t;

    typedef struct packed {
        logic       latch;
        logic       cursor_zero;
        logic       cursor_inc;
        logic       set_status;
        logic [1:0] status_code;
        logic       open_setup;
        logic       close_setup;
        logic       shift_read;
        logic       shift_write;
        logic       put_word;
        logic       count_dec;
        logic       idx_read;
        logic       idx_capture;
        logic       cur_read;
        logic       load_out;
    } csb_ctrl_t;

    typedef struct packed {
        logic [2:0] kind;
        logic       has_item;
        logic       full;
        logic       idx_ok;
        logic       shift_more;
        logic       dir_up;
        logic       rsp_free;
    } csb_stat_t;

endpackage

// ===== hw/rtl/csb_ctrl.sv =====
// ----------------------------------------------------------------------------
// csb_ctrl: command sequencer
// Steps each accepted item through decode, entry shifting, reads of the
// store and the hand-off of the result to the output register.
// ----------------------------------------------------------------------------
module csb_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    output logic               cmd_ready,
    input  csb_pkg::csb_stat_t stat,
    output csb_pkg::csb_ctrl_t ctrl
);
    import csb_pkg::*;

    localparam logic [2:0] S_IDLE      = 3'd0;
    localparam logic [2:0] S_DECODE    = 3'd1;
    localparam logic [2:0] S_SHIFT_CHK = 3'd2;
    localparam logic [2:0] S_SHIFT_WR  = 3'd3;
    localparam logic [2:0] S_IDX_CAP   = 3'd4;
    localparam logic [2:0] S_CUR_RD    = 3'd5;
    localparam logic [2:0] S_DONE      = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ctrl       = '0;
        cmd_ready  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                cmd_ready = 1'b1;
                if (cmd_valid)
                begin
                    ctrl.latch = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                state_next = S_CUR_RD;
                case (stat.kind)
                    KIND_START:
                    begin
                        ctrl.cursor_zero = 1'b1;
                    end
                    KIND_ADVANCE:
                    begin
                        if (stat.has_item)
                        begin
                            ctrl.cursor_inc = 1'b1;
                        end
                        else
                        begin
                            ctrl.set_status  = 1'b1;
                            ctrl.status_code = ST_NO_ITEM;
                        end
                    end
                    KIND_INSERT, KIND_ATTACH:
                    begin
                        if (stat.full)
                        begin
                            ctrl.set_status  = 1'b1;
                            ctrl.status_code = ST_FULL;
                        end
                        else
                        begin
                            ctrl.open_setup = 1'b1;
                            state_next      = S_SHIFT_CHK;
                        end
                    end
                    KIND_REMOVE:
                    begin
                        if (stat.has_item)
                        begin
                            ctrl.close_setup = 1'b1;
                            state_next       = S_SHIFT_CHK;
                        end
                        else
                        begin
                            ctrl.set_status  = 1'b1;
                            ctrl.status_code = ST_NO_ITEM;
                        end
                    end
                    KIND_READ:
                    begin
                        if (stat.idx_ok)
                        begin
                            ctrl.idx_read = 1'b1;
                            state_next    = S_IDX_CAP;
                        end
                        else
                        begin
                            ctrl.set_status  = 1'b1;
                            ctrl.status_code = ST_RANGE;
                        end
                    end
                    default:
                    begin
                        state_next = S_CUR_RD;
                    end
                endcase
            end
            S_SHIFT_CHK:
            begin
                if (stat.shift_more)
                begin
                    ctrl.shift_read = 1'b1;
                    state_next      = S_SHIFT_WR;
                end
                else if (stat.dir_up)
                begin
                    ctrl.put_word = 1'b1;
                    state_next    = S_CUR_RD;
                end
                else
                begin
                    ctrl.count_dec = 1'b1;
                    state_next     = S_CUR_RD;
                end
            end
            S_SHIFT_WR:
            begin
                ctrl.shift_write = 1'b1;
                state_next       = S_SHIFT_CHK;
            end
            S_IDX_CAP:
            begin
                ctrl.idx_capture = 1'b1;
                state_next       = S_CUR_RD;
            end
            S_CUR_RD:
            begin
                ctrl.cur_read = 1'b1;
                state_next    = S_DONE;
            end
            S_DONE:
            begin
                if (stat.rsp_free)
                begin
                    ctrl.load_out = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== hw/rtl/csb_datapath.sv =====
// ----------------------------------------------------------------------------
// csb_datapath: entry store, cursor, count and result register
// Entry memory with one read and one write port and registered read, shift
// pointer, command latch and the output register of the result channel.
// ----------------------------------------------------------------------------
module csb_datapath #(
    parameter int CAPACITY   = csb_pkg::CSB_CAPACITY,
    parameter int DATA_WIDTH = csb_pkg::CSB_DATA_WIDTH
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  csb_pkg::csb_cmd_item_t cmd,
    input  csb_pkg::csb_ctrl_t     ctrl,
    output csb_pkg::csb_stat_t     stat,
    output logic                   rsp_valid,
    input  logic                   rsp_ready,
    output csb_pkg::csb_rsp_item_t rsp
);
    import csb_pkg::*;

    localparam int AW  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW  = $clog2(CAPACITY + 1);
    localparam int IXW = (CW > 6) ? CW : 6;

    logic [DATA_WIDTH-1:0] mem [CAPACITY];

    logic [CW-1:0]         count_reg;
    logic [CW-1:0]         count_next;
    logic [CW-1:0]         cursor_reg;
    logic [CW-1:0]         cursor_next;
    logic                  rsp_valid_reg;
    logic                  rsp_valid_next;

    logic [CW-1:0]         ptr_reg;
    logic                  dir_up_reg;
    logic [2:0]            kind_reg;
    logic [DATA_WIDTH-1:0] word_reg;
    logic [5:0]            idx_reg;
    logic [1:0]            status_reg;
    logic [31:0]           read_value_reg;
    logic [DATA_WIDTH-1:0] rd_data_reg;
    csb_rsp_item_t         rsp_reg;

    logic                  has_item;
    logic                  full;
    logic                  idx_ok;
    logic                  shift_more;
    logic [CW-1:0]         ptr_dn;
    logic [CW-1:0]         ptr_up;
    logic [CW-1:0]         open_pos;
    logic [AW-1:0]         rd_addr;
    logic [AW-1:0]         wr_addr;
    logic                  rd_en;
    logic                  wr_en;
    logic [DATA_WIDTH-1:0] wr_data;
    csb_rsp_item_t         rsp_next;

    assign has_item   = cursor_reg < count_reg;
    assign full       = count_reg >= CW'(CAPACITY);
    assign idx_ok     = (IXW'(idx_reg) < IXW'(count_reg)) && (IXW'(idx_reg) < IXW'(CAPACITY));
    assign ptr_dn     = ptr_reg - CW'(1);
    assign ptr_up     = ptr_reg + CW'(1);
    assign shift_more = dir_up_reg ? (ptr_reg > cursor_reg)
                                   : (({1'b0, ptr_reg} + (CW+1)'(1)) < {1'b0, count_reg});

    always_comb
    begin
        if (kind_reg == KIND_ATTACH)
        begin
            open_pos = has_item ? (cursor_reg + CW'(1)) : count_reg;
        end
        else
        begin
            open_pos = has_item ? cursor_reg : '0;
        end
    end

    assign stat.kind       = kind_reg;
    assign stat.has_item   = has_item;
    assign stat.full       = full;
    assign stat.idx_ok     = idx_ok;
    assign stat.shift_more = shift_more;
    assign stat.dir_up     = dir_up_reg;
    assign stat.rsp_free   = !rsp_valid_reg || rsp_ready;

    // single read port
    always_comb
    begin
        rd_en   = ctrl.shift_read || ctrl.idx_read || ctrl.cur_read;
        rd_addr = cursor_reg[AW-1:0];
        if (ctrl.shift_read)
        begin
            rd_addr = dir_up_reg ? ptr_dn[AW-1:0] : ptr_up[AW-1:0];
        end
        else if (ctrl.idx_read)
        begin
            rd_addr = AW'(idx_reg);
        end
    end

    // single write port
    always_comb
    begin
        wr_en   = ctrl.shift_write || ctrl.put_word;
        wr_addr = ctrl.put_word ? cursor_reg[AW-1:0] : ptr_reg[AW-1:0];
        wr_data = ctrl.put_word ? word_reg : rd_data_reg;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_comb
    begin
        count_next     = count_reg;
        cursor_next    = cursor_reg;
        rsp_valid_next = rsp_valid_reg;
        if (ctrl.cursor_zero)
        begin
            cursor_next = '0;
        end
        if (ctrl.cursor_inc)
        begin
            cursor_next = cursor_reg + CW'(1);
        end
        if (ctrl.open_setup)
        begin
            cursor_next = open_pos;
        end
        if (ctrl.put_word)
        begin
            count_next = count_reg + CW'(1);
        end
        if (ctrl.count_dec)
        begin
            count_next = count_reg - CW'(1);
        end
        if (ctrl.load_out)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            cursor_reg    <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            cursor_reg    <= cursor_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_comb
    begin
        rsp_next.status          = status_reg;
        rsp_next.current_valid   = has_item;
        rsp_next.current_value   = has_item ? 32'(rd_data_reg) : 32'd0;
        rsp_next.read_value      = read_value_reg;
        rsp_next.item_count      = 7'(count_reg);
        rsp_next.cursor_position = 7'(cursor_reg);
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.latch)
        begin
            kind_reg       <= cmd.kind;
            word_reg       <= DATA_WIDTH'(cmd.entry_value);
            idx_reg        <= cmd.read_index;
            status_reg     <= ST_OK;
            read_value_reg <= '0;
        end
        if (ctrl.set_status)
        begin
            status_reg <= ctrl.status_code;
        end
        if (ctrl.idx_capture)
        begin
            read_value_reg <= 32'(rd_data_reg);
        end
        if (ctrl.open_setup)
        begin
            ptr_reg    <= count_reg;
            dir_up_reg <= 1'b1;
        end
        if (ctrl.close_setup)
        begin
            ptr_reg    <= cursor_reg;
            dir_up_reg <= 1'b0;
        end
        if (ctrl.shift_write)
        begin
            ptr_reg <= dir_up_reg ? ptr_dn : ptr_up;
        end
        if (ctrl.load_out)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

// ===== hw/rtl/cursor_sequence_buffer_core.sv =====
// ----------------------------------------------------------------------------
// cursor_sequence_buffer_core: ordered word store with a cursor
// Commands come in on cmd (valid/ready), one result per command leaves on rsp
// (valid/ready). Each command rewinds or advances the cursor, inserts before
// or attaches after the current entry, removes it, or reads an entry by index.
// Each command passes decode, a read of the current entry and the load of
// the output register; a read by index adds an indexed read and capture, and
// an insert, attach or remove adds a shift for each of the n entries moved
// (n up to CAPACITY-1). Entries move one at a time through the memory ports,
// a read then a write per entry, which sets the cost of insert and remove. One
// command is in flight at a time; a new one can be taken in the cycle after
// the previous result is loaded into the output register, even while that
// result is still held. A stalled receiver holds the result in the output
// register and blocks completion of the following command until it is taken.
// Reset empties the store (count and cursor zero) and drops any pending
// result; entry contents are not cleared and need no sweep.
// ----------------------------------------------------------------------------
module cursor_sequence_buffer_core #(
    parameter int CAPACITY   = csb_pkg::CSB_CAPACITY,
    parameter int DATA_WIDTH = csb_pkg::CSB_DATA_WIDTH
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cmd_valid,
    output logic                   cmd_ready,
    input  csb_pkg::csb_cmd_item_t cmd,
    output logic                   rsp_valid,
    input  logic                   rsp_ready,
    output csb_pkg::csb_rsp_item_t rsp
);
    import csb_pkg::*;

    csb_ctrl_t ctrl;
    csb_stat_t stat;

    csb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .stat      (stat),
        .ctrl      (ctrl)
    );

    csb_datapath #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .ctrl      (ctrl),
        .stat      (stat),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

`ifndef ASSERT_OFF
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid && cmd_ready) |=> !cmd_ready)
        else $error("command accepted while another is in flight");

    a_no_current_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp.current_valid) |-> (rsp.current_value == 32'd0))
        else $error("current value nonzero with no current item");

    a_range_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.status == ST_RANGE) |-> (rsp.read_value == 32'd0))
        else $error("read value nonzero on index out of range");

    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.load_out |-> (!rsp_valid || rsp_ready))
        else $error("result overwritten before it was taken");
`endif

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: command stream check of cursor_sequence_buffer_core
// Sends a short directed sequence, then random command mixes that fill the
// store to capacity and drain it, with random idling on both handshakes and
// long receiver hold-offs. A behavioral copy of the store, count and cursor
// predicts every result, and each returned field is compared in order.
// ----------------------------------------------------------------------------
module testbench;
    import csb_pkg::*;

    localparam logic [2:0] KIND_SPARE_6 = 3'd6;
    localparam logic [2:0] KIND_SPARE_7 = 3'd7;
    localparam int HOLD_CYCLES   = 200;
    localparam int STALL_LIMIT   = 5000;
    localparam int SETTLE_CYCLES = 20;

    typedef enum int {MIX_BALANCED, MIX_GROW, MIX_SHRINK} cmd_mix_t;

    logic          clk = 1'b0;
    logic          rst_n = 1'b0;
    logic          cmd_valid = 1'b0;
    logic          cmd_ready;
    csb_cmd_item_t cmd = '0;
    logic          rsp_valid;
    logic          rsp_ready = 1'b0;
    csb_rsp_item_t rsp;

    csb_cmd_item_t pending_cmds[$];
    csb_rsp_item_t expected_rsps[$];
    logic [31:0]   store_words[CSB_CAPACITY];
    int            store_count = 0;
    int            store_cursor = 0;

    int   send_idle_pct = 23;
    int   recv_idle_pct = 50;
    int   hold_reqs = 0;
    int   hold_seen = 0;
    int   hold_left = 0;
    int   stall_cycles = 0;
    int   mismatches = 0;
    logic cmd_taken = 1'b0;

    cursor_sequence_buffer_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic csb_rsp_item_t apply_command(csb_cmd_item_t c);
        csb_rsp_item_t r;
        logic          has_item;
        int            i;
        r = '0;
        has_item = store_cursor < store_count;
        case (c.kind)
            KIND_START:
                store_cursor = 0;
            KIND_ADVANCE:
                if (has_item)
                    store_cursor++;
                else
                    r.status = ST_NO_ITEM;
            KIND_INSERT, KIND_ATTACH:
                if (store_count >= CSB_CAPACITY)
                    r.status = ST_FULL;
                else
                begin
                    if (c.kind == KIND_INSERT)
                    begin
                        if (!has_item)
                            store_cursor = 0;
                    end
                    else if (!has_item)
                        store_cursor = store_count;
                    else
                        store_cursor++;
                    for (i = store_count; i > store_cursor; i--)
                        store_words[i] = store_words[i - 1];
                    store_words[store_cursor] = c.entry_value;
                    store_count++;
                end
            KIND_REMOVE:
                if (!has_item)
                    r.status = ST_NO_ITEM;
                else
                begin
                    for (i = store_cursor; i + 1 < store_count; i++)
                        store_words[i] = store_words[i + 1];
                    store_count--;
                end
            KIND_READ:
                if (c.read_index < store_count)
                    r.read_value = store_words[c.read_index];
                else
                    r.status = ST_RANGE;
            default:
                ;
        endcase
        r.current_valid   = store_cursor < store_count;
        r.current_value   = r.current_valid ? store_words[store_cursor] : 32'd0;
        r.item_count      = 7'(store_count);
        r.cursor_position = 7'(store_cursor);
        return r;
    endfunction

    function automatic logic [2:0] draw_kind(cmd_mix_t mix);
        int roll;
        int lim_start;
        int lim_adv;
        int lim_ins;
        int lim_att;
        int lim_rem;
        int lim_read;
        roll = $urandom_range(0, 99);
        case (mix)
            MIX_GROW:
            begin
                lim_start = 3; lim_adv = 8; lim_ins = 46;
                lim_att = 84; lim_rem = 87; lim_read = 98;
            end
            MIX_SHRINK:
            begin
                lim_start = 15; lim_adv = 20; lim_ins = 24;
                lim_att = 28; lim_rem = 86; lim_read = 98;
            end
            default:
            begin
                lim_start = 8; lim_adv = 26; lim_ins = 44;
                lim_att = 62; lim_rem = 80; lim_read = 96;
            end
        endcase
        if (roll < lim_start)
            return KIND_START;
        if (roll < lim_adv)
            return KIND_ADVANCE;
        if (roll < lim_ins)
            return KIND_INSERT;
        if (roll < lim_att)
            return KIND_ATTACH;
        if (roll < lim_rem)
            return KIND_REMOVE;
        if (roll < lim_read)
            return KIND_READ;
        return $urandom_range(0, 1) ? KIND_SPARE_7 : KIND_SPARE_6;
    endfunction

    task automatic push_cmd(logic [2:0] kind, logic [31:0] value, logic [5:0] index);
        csb_cmd_item_t c;
        c.kind        = kind;
        c.entry_value = value;
        c.read_index  = index;
        pending_cmds.push_back(c);
    endtask

    task automatic queue_commands(int n, cmd_mix_t mix);
        logic [31:0] value;
        logic [5:0]  index;
        int          roll;
        repeat (n)
        begin
            roll = $urandom_range(0, 9);
            if (roll == 0)
                value = 32'd0;
            else if (roll == 1)
                value = 32'hffff_ffff;
            else
                value = $urandom;
            if ($urandom_range(0, 1) != 0)
                index = 6'($urandom_range(0, 15));
            else
                index = 6'($urandom_range(0, 63));
            push_cmd(draw_kind(mix), value, index);
        end
    endtask

    task automatic wait_for_drain();
        while (pending_cmds.size() != 0 || cmd_valid || expected_rsps.size() != 0)
            @(posedge clk);
    endtask

    task automatic note_mismatch(string what, logic [31:0] got, logic [31:0] want);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t: %s got %h want %h", $time, what, got, want);
    endtask

    task automatic check_field(string what, logic [31:0] got, logic [31:0] want);
        if (got !== want)
            note_mismatch(what, got, want);
    endtask

    // command side: record acceptance and predict
    always @(posedge clk)
    begin
        cmd_taken = cmd_valid && cmd_ready;
        if (cmd_taken)
            expected_rsps.push_back(apply_command(cmd));
    end

    always @(negedge clk)
    begin
        if (rst_n && (!cmd_valid || cmd_taken))
        begin
            if (pending_cmds.size() > 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                cmd       <= pending_cmds.pop_front();
                cmd_valid <= 1'b1;
            end
            else
                cmd_valid <= 1'b0;
        end
    end

    // result side: ready with random idling and requested hold-offs
    always @(negedge clk)
    begin
        if (hold_seen != hold_reqs)
        begin
            hold_seen = hold_reqs;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            rsp_ready <= 1'b0;
        end
        else
            rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin : rsp_monitor
        csb_rsp_item_t want;
        if (rsp_valid && rsp_ready)
        begin
            if (expected_rsps.size() == 0)
                note_mismatch("result with nothing expected, item_count",
                              32'(rsp.item_count), 32'd0);
            else
            begin
                want = expected_rsps.pop_front();
                check_field("status", 32'(rsp.status), 32'(want.status));
                check_field("current_valid", 32'(rsp.current_valid),
                            32'(want.current_valid));
                check_field("current_value", rsp.current_value, want.current_value);
                check_field("read_value", rsp.read_value, want.read_value);
                check_field("item_count", 32'(rsp.item_count), 32'(want.item_count));
                check_field("cursor_position", 32'(rsp.cursor_position),
                            32'(want.cursor_position));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((cmd_valid && cmd_ready) || (rsp_valid && rsp_ready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("cursor_sequence_buffer_core: mismatch");
            $finish;
        end
    end

    initial
    begin
        // empty store cases
        push_cmd(KIND_START, 32'd0, 6'd0);
        push_cmd(KIND_ADVANCE, 32'd0, 6'd0);
        push_cmd(KIND_REMOVE, 32'd0, 6'd0);
        push_cmd(KIND_READ, 32'd0, 6'd0);
        // insert to front, attach after current and at the end
        push_cmd(KIND_INSERT, 32'hffff_ffff, 6'd0);
        push_cmd(KIND_ATTACH, 32'h0000_0000, 6'd0);
        push_cmd(KIND_ADVANCE, 32'd0, 6'd0);
        push_cmd(KIND_ATTACH, 32'ha5a5_a5a5, 6'd0);
        push_cmd(KIND_ADVANCE, 32'd0, 6'd0);
        push_cmd(KIND_INSERT, 32'h5a5a_5a5a, 6'd0);
        push_cmd(KIND_ADVANCE, 32'd0, 6'd0);
        push_cmd(KIND_INSERT, 32'h1234_5678, 6'd0);
        // reads in and out of range
        push_cmd(KIND_READ, 32'd0, 6'd3);
        push_cmd(KIND_READ, 32'd0, 6'd63);
        push_cmd(KIND_READ, 32'd0, 6'd4);
        push_cmd(KIND_READ, 32'd0, 6'd5);
        push_cmd(KIND_SPARE_6, 32'd0, 6'd0);
        push_cmd(KIND_SPARE_7, 32'hffff_ffff, 6'd63);
        // remove the first, then the last item
        push_cmd(KIND_START, 32'd0, 6'd0);
        push_cmd(KIND_REMOVE, 32'd0, 6'd0);
        push_cmd(KIND_ADVANCE, 32'd0, 6'd0);
        push_cmd(KIND_ADVANCE, 32'd0, 6'd0);
        push_cmd(KIND_ADVANCE, 32'd0, 6'd0);
        push_cmd(KIND_REMOVE, 32'd0, 6'd0);
        push_cmd(KIND_REMOVE, 32'd0, 6'd0);

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        wait_for_drain();

        queue_commands(110, MIX_GROW);
        hold_reqs++;
        queue_commands(150, MIX_BALANCED);
        wait_for_drain();

        send_idle_pct = 50;
        recv_idle_pct = 23;
        queue_commands(100, MIX_SHRINK);
        wait_for_drain();
        queue_commands(150, MIX_BALANCED);
        wait_for_drain();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        queue_commands(110, MIX_GROW);
        hold_reqs++;
        queue_commands(100, MIX_SHRINK);
        queue_commands(50, MIX_BALANCED);
        wait_for_drain();

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0 && expected_rsps.size() == 0)
            $display("cursor_sequence_buffer_core: match");
        else
            $display("cursor_sequence_buffer_core: mismatch");
        $finish;
    end
endmodule
